>>> design/lrn_ccf_pkg.sv
package lrn_ccf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AlphaW = 24;
  localparam int unsigned BetaW = 8;
  localparam int unsigned SizeW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxWindow = 15;
  localparam int unsigned RingDepth = 16;
  localparam int unsigned RingW = 4;
  localparam int unsigned SqW = 31;
  localparam int unsigned SumW = 34;
  localparam int unsigned ScaleW = 43;
  localparam int unsigned RootW = 30;
  localparam int unsigned PowSteps = 16;

  localparam logic [CfgIdxW-1:0] RegAlpha = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBeta = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindow = 2'd2;

  localparam logic [AlphaW-1:0] AlphaReset = 24'd1678;
  localparam logic [BetaW-1:0] BetaReset = 8'd192;
  localparam logic [SizeW-1:0] WindowReset = 4'd5;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic last_channel;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] normalized;
    logic last_of_pixel;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SINIT,
    S_SUM,
    S_MLO,
    S_MHI,
    S_NORM,
    S_LOG,
    S_EXPO,
    S_POW,
    S_PRD,
    S_RND,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    logic accept;
    logic sum_init;
    logic sum_step;
    logic mul_lo;
    logic mul_hi;
    logic norm_step;
    logic log_step;
    logic expo;
    logic pow_step;
    logic prod;
    logic round;
    logic next_d;
  } cmd_t;

  typedef struct packed {
    logic emit_now;
    logic sum_last;
    logic norm_done;
    logic step_last;
    logic more_emits;
  } sts_t;

  typedef logic [PowSteps-1:0][RootW-1:0] root_table_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x = v;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // factors 2^(-2^-k), k = 1..16, Q0.30
  function automatic root_table_t root_table();
    root_table_t t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int i = 0; i < PowSteps; i++) begin
      t[i] = r[RootW-1:0];
      r = isqrt64(r << 30);
    end
    return t;
  endfunction

  localparam root_table_t RootTable = root_table();

endpackage

>>> design/lrn_ccf_ctrl.sv
module lrn_ccf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_stall_i,
  input  lrn_ccf_pkg::sts_t   sts_i,
  output lrn_ccf_pkg::cmd_t   cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);

  lrn_ccf_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrn_ccf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrn_ccf_pkg::S_IDLE: begin
        if (in_valid_i && sts_i.emit_now) state_d = lrn_ccf_pkg::S_SINIT;
      end
      lrn_ccf_pkg::S_SINIT: state_d = lrn_ccf_pkg::S_SUM;
      lrn_ccf_pkg::S_SUM: begin
        if (sts_i.sum_last) state_d = lrn_ccf_pkg::S_MLO;
      end
      lrn_ccf_pkg::S_MLO: state_d = lrn_ccf_pkg::S_MHI;
      lrn_ccf_pkg::S_MHI: state_d = lrn_ccf_pkg::S_NORM;
      lrn_ccf_pkg::S_NORM: begin
        if (sts_i.norm_done) state_d = lrn_ccf_pkg::S_LOG;
      end
      lrn_ccf_pkg::S_LOG: begin
        if (sts_i.step_last) state_d = lrn_ccf_pkg::S_EXPO;
      end
      lrn_ccf_pkg::S_EXPO: state_d = lrn_ccf_pkg::S_POW;
      lrn_ccf_pkg::S_POW: begin
        if (sts_i.step_last) state_d = lrn_ccf_pkg::S_PRD;
      end
      lrn_ccf_pkg::S_PRD: state_d = lrn_ccf_pkg::S_RND;
      lrn_ccf_pkg::S_RND: state_d = lrn_ccf_pkg::S_OUT;
      lrn_ccf_pkg::S_OUT: begin
        if (!out_stall_i) begin
          state_d = sts_i.more_emits ? lrn_ccf_pkg::S_SINIT : lrn_ccf_pkg::S_IDLE;
        end
      end
      default: state_d = lrn_ccf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      lrn_ccf_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      lrn_ccf_pkg::S_SINIT: cmd_o.sum_init = 1'b1;
      lrn_ccf_pkg::S_SUM:   cmd_o.sum_step = 1'b1;
      lrn_ccf_pkg::S_MLO:   cmd_o.mul_lo = 1'b1;
      lrn_ccf_pkg::S_MHI:   cmd_o.mul_hi = 1'b1;
      lrn_ccf_pkg::S_NORM:  cmd_o.norm_step = 1'b1;
      lrn_ccf_pkg::S_LOG:   cmd_o.log_step = 1'b1;
      lrn_ccf_pkg::S_EXPO:  cmd_o.expo = 1'b1;
      lrn_ccf_pkg::S_POW:   cmd_o.pow_step = 1'b1;
      lrn_ccf_pkg::S_PRD:   cmd_o.prod = 1'b1;
      lrn_ccf_pkg::S_RND:   cmd_o.round = 1'b1;
      lrn_ccf_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.next_d = !out_stall_i && sts_i.more_emits;
      end
      default: cmd_o = '0;
    endcase
  end

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  a_flush_or_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrn_ccf_pkg::S_OUT && !out_stall_i) |=>
    (state_q == lrn_ccf_pkg::S_SINIT || state_q == lrn_ccf_pkg::S_IDLE))
    else $error("bad exit from output state");

  a_log_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrn_ccf_pkg::S_LOG && sts_i.step_last) |=> state_q == lrn_ccf_pkg::S_EXPO)
    else $error("log loop did not end after sixteen steps");

endmodule

>>> design/lrn_ccf_dp.sv
module lrn_ccf_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lrn_ccf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lrn_ccf_pkg::AlphaW-1:0]         cfg_data_i,
  input  lrn_ccf_pkg::in_word_t                  in_word_i,
  input  lrn_ccf_pkg::cmd_t                      cmd_i,
  output lrn_ccf_pkg::sts_t                      sts_o,
  output lrn_ccf_pkg::out_word_t                 out_word_o
);

  localparam int unsigned SumW = lrn_ccf_pkg::SumW;

  logic [lrn_ccf_pkg::AlphaW-1:0] alpha_q;
  logic [lrn_ccf_pkg::BetaW-1:0]  beta_q;
  logic [lrn_ccf_pkg::SizeW-1:0]  wsize_q;

  logic [lrn_ccf_pkg::SampleW-1:0] samp_q [lrn_ccf_pkg::RingDepth];
  logic [lrn_ccf_pkg::SqW-1:0]     sqr_q  [lrn_ccf_pkg::RingDepth];

  logic [lrn_ccf_pkg::RingW-1:0] head_q, hj_q, j_q, dlo_q;
  logic [15:0] chan_q, kj_q;
  logic [lrn_ccf_pkg::SizeW-1:0] active_q;
  logic [2:0] pre_q, post_q, d_q;
  logic last_q;
  logic [lrn_ccf_pkg::SumW-1:0] sum_q;
  logic [lrn_ccf_pkg::SampleW-1:0] raw_q;
  logic [40:0] acc_q;
  logic [lrn_ccf_pkg::ScaleW-1:0] scale_q;
  logic [4:0] shf_q;
  logic [30:0] m_q;
  logic [15:0] frac_q;
  logic [3:0] cnt_q;
  logic [28:0] e_q;
  logic [30:0] p_q;
  logic [46:0] prod_q;
  lrn_ccf_pkg::out_word_t out_q;

  logic [lrn_ccf_pkg::SizeW-1:0] clamp_c, size_c;
  logic [2:0] pre_c, post_c, dacc_c, dhi_c;
  logic [3:0] dpre_c, dlo_c;
  logic signed [31:0] sq_full;
  logic [40:0] hi_c;
  logic [57:0] prod_full;
  logic [41:0] scaled;
  logic [61:0] msq;
  logic [31:0] msh;
  logic [60:0] pw;
  logic [20:0] lg;
  logic [15:0] mag;
  logic [5:0] sh;
  logic [61:0] rnd, qv;
  logic [15:0] res;

  always_comb begin
    if (wsize_q == '0) clamp_c = 4'd1;
    else if (32'(wsize_q) > lrn_ccf_pkg::MaxWindow) clamp_c = 4'(lrn_ccf_pkg::MaxWindow);
    else clamp_c = wsize_q;
    size_c = (chan_q == '0) ? clamp_c : active_q;
    pre_c = 3'((size_c - 4'd1) >> 1);
    post_c = 3'(size_c - 4'd1 - {1'b0, pre_c});
    dacc_c = (!in_word_i.last_channel || chan_q >= 16'(post_c)) ? post_c : chan_q[2:0];
    sq_full = in_word_i.sample * in_word_i.sample;
    dpre_c = {1'b0, d_q} + {1'b0, pre_q};
    dlo_c = (16'(dpre_c) > kj_q) ? kj_q[3:0] : dpre_c;
    dhi_c = (d_q >= post_q) ? d_q - post_q : 3'd0;
    hi_c = alpha_q * sum_q[33:17];
    prod_full = {17'd0, acc_q} + {hi_c, 17'd0};
    scaled = prod_full[57:16];
    msq = m_q * m_q;
    msh = msq[61:30];
    pw = 61'(p_q) * 61'(lrn_ccf_pkg::RootTable[cnt_q]);
    lg = {5'd18 - shf_q, frac_q};
    mag = raw_q[15] ? 16'(17'h10000 - {1'b0, raw_q}) : raw_q;
    sh = 6'd30 + {1'b0, e_q[28:24]};
    rnd = {15'd0, prod_q} + (62'd1 << (sh - 6'd1));
    qv = rnd >> sh;
    if (raw_q[15]) begin
      res = (qv > 62'd32768) ? 16'h8000 : 16'(17'h10000 - {1'b0, qv[15:0]});
    end else begin
      res = (qv > 62'd32767) ? 16'h7fff : qv[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= lrn_ccf_pkg::AlphaReset;
      beta_q <= lrn_ccf_pkg::BetaReset;
      wsize_q <= lrn_ccf_pkg::WindowReset;
      head_q <= '0;
      chan_q <= '0;
      active_q <= lrn_ccf_pkg::WindowReset;
      last_q <= 1'b0;
      d_q <= '0;
      pre_q <= '0;
      post_q <= '0;
      cnt_q <= '0;
      j_q <= '0;
      shf_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lrn_ccf_pkg::RegAlpha:  alpha_q <= cfg_data_i;
          lrn_ccf_pkg::RegBeta:   beta_q <= cfg_data_i[lrn_ccf_pkg::BetaW-1:0];
          lrn_ccf_pkg::RegWindow: wsize_q <= cfg_data_i[lrn_ccf_pkg::SizeW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        head_q <= head_q + 4'd1;
        active_q <= size_c;
        pre_q <= pre_c;
        post_q <= post_c;
        d_q <= dacc_c;
        last_q <= in_word_i.last_channel;
        if (in_word_i.last_channel) chan_q <= '0;
        else if (chan_q != 16'hffff) chan_q <= chan_q + 16'd1;
      end
      if (cmd_i.sum_init) j_q <= {1'b0, dhi_c};
      if (cmd_i.sum_step) j_q <= j_q + 4'd1;
      if (cmd_i.next_d) d_q <= d_q - 3'd1;
      if (cmd_i.mul_hi) shf_q <= '0;
      if (cmd_i.norm_step) begin
        if (!scale_q[lrn_ccf_pkg::ScaleW-1]) shf_q <= shf_q + 5'd1;
        else cnt_q <= '0;
      end
      if (cmd_i.log_step || cmd_i.pow_step) cnt_q <= cnt_q + 4'd1;
      if (cmd_i.expo) cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      samp_q[head_q] <= in_word_i.sample;
      sqr_q[head_q] <= sq_full[lrn_ccf_pkg::SqW-1:0];
      hj_q <= head_q;
      kj_q <= chan_q;
    end
    if (cmd_i.sum_init) begin
      sum_q <= '0;
      dlo_q <= dlo_c;
      raw_q <= samp_q[hj_q - {1'b0, d_q}];
    end
    if (cmd_i.sum_step) sum_q <= sum_q + SumW'(sqr_q[hj_q - j_q]);
    if (cmd_i.mul_lo) acc_q <= alpha_q * sum_q[16:0];
    if (cmd_i.mul_hi) scale_q <= {1'b0, scaled} + (43'd2 << 24);
    if (cmd_i.norm_step) begin
      if (!scale_q[lrn_ccf_pkg::ScaleW-1]) scale_q <= scale_q << 1;
      else begin
        m_q <= scale_q[42:12];
        frac_q <= '0;
      end
    end
    if (cmd_i.log_step) begin
      m_q <= msh[31] ? msh[31:1] : msh[30:0];
      frac_q <= {frac_q[14:0], msh[31]};
    end
    if (cmd_i.expo) begin
      e_q <= 29'(beta_q) * 29'(lg);
      p_q <= 31'd1 << 30;
    end
    if (cmd_i.pow_step && e_q[5'd23 - {1'b0, cnt_q}]) p_q <= pw[60:30];
    if (cmd_i.prod) prod_q <= 47'(mag) * 47'(p_q);
    if (cmd_i.round) begin
      out_q.normalized <= res;
      out_q.last_of_pixel <= last_q && (d_q == '0);
    end
  end

  assign sts_o.emit_now = in_word_i.last_channel || (chan_q >= 16'(post_c));
  assign sts_o.sum_last = (j_q == dlo_q);
  assign sts_o.norm_done = scale_q[lrn_ccf_pkg::ScaleW-1];
  assign sts_o.step_last = (cnt_q == 4'd15);
  assign sts_o.more_emits = last_q && (d_q != '0);
  assign out_word_o = out_q;

endmodule

>>> design/lrn_cross_channel_forward_core.sv
// Each released result runs through the window sum, normalize, 16 log steps
// and 16 power steps.
// Throughput: one input word per cycle while no result is due; a word that
// releases results is taken, and later words stall until all are taken;
// a last-channel word releases up to eight, each taking the full sequence.
// Reset: alpha 1678, beta 192, window size 5, channel count and ring head cleared.
module lrn_cross_channel_forward_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lrn_ccf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lrn_ccf_pkg::AlphaW-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lrn_ccf_pkg::in_word_t                in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lrn_ccf_pkg::out_word_t               out_word_o
);

  lrn_ccf_pkg::cmd_t cmd;
  lrn_ccf_pkg::sts_t sts;

  lrn_ccf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  lrn_ccf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

>>> sim/tb_lrn_cross_channel_forward_core.sv
module tb_lrn_cross_channel_forward_core;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lrn_ccf_pkg::CfgIdxW-1:0] cfg_index_i = lrn_ccf_pkg::RegAlpha;
  logic [lrn_ccf_pkg::AlphaW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lrn_ccf_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lrn_ccf_pkg::out_word_t out_word_o;

  lrn_cross_channel_forward_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] sq_ring [lrn_ccf_pkg::RingDepth];
  logic [15:0] smp_ring [lrn_ccf_pkg::RingDepth];
  int unsigned chan_idx = 0;
  logic [3:0] ring_head = '0;
  int unsigned win_len = 5;
  logic [23:0] alpha_cfg = lrn_ccf_pkg::AlphaReset;
  logic [7:0] beta_cfg = lrn_ccf_pkg::BetaReset;
  logic [3:0] win_cfg = lrn_ccf_pkg::WindowReset;

  lrn_ccf_pkg::in_word_t pending_words[$];
  lrn_ccf_pkg::out_word_t expected_norm[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit no_idle = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit took;

  initial begin
    for (int i = 0; i < lrn_ccf_pkg::RingDepth; i++) begin
      sq_ring[i] = '0;
      smp_ring[i] = '0;
    end
  end

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_q16(input logic [63:0] s);
    int unsigned e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = '0;
    while (e < 63 && (s >> (e + 1)) != 0) e++;
    m = (e > 30) ? (s >> (e - 30)) : (s << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e - 24) << 16) | frac;
  endfunction

  function automatic logic [15:0] normalize_one(input logic [15:0] raw, input logic [63:0] sum);
    logic [63:0] scale;
    logic [63:0] ex;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] sh;
    scale = (64'd2 << 24) + ((64'(alpha_cfg) * sum) >> 16);
    ex = 64'(beta_cfg) * log2_q16(scale);
    n = ex >> 24;
    f = ex & 64'hFF_FFFF;
    p = 64'd1 << 30;
    r = root64(64'd1 << 59);
    for (int k = 1; k <= 16; k++) begin
      if ((f >> (24 - k)) & 64'd1) p = (p * r) >> 30;
      r = root64(r << 30);
    end
    mag = raw[15] ? 64'(17'h10000 - raw) : 64'(raw);
    sh = 30 + n;
    q = (sh >= 62) ? 64'd0 : ((mag * p + (64'd1 << (sh - 1))) >> sh);
    if (raw[15]) begin
      if (q > 32768) q = 32768;
      return 16'(17'h10000 - q);
    end
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  function automatic lrn_ccf_pkg::out_word_t lrn_of(input int unsigned k,
                                                    input int unsigned d,
                                                    input int unsigned pre,
                                                    input int unsigned post,
                                                    input bit lastf);
    int unsigned dlo;
    int unsigned dhi;
    logic [63:0] sum;
    logic [3:0] slot;
    lrn_ccf_pkg::out_word_t o;
    dlo = d + pre;
    if (dlo > k) dlo = k;
    dhi = (d >= post) ? d - post : 0;
    sum = '0;
    for (int unsigned j = dhi; j <= dlo; j++) begin
      slot = ring_head - 4'(j);
      sum += 64'(sq_ring[slot]);
    end
    slot = ring_head - 4'(d);
    o.normalized = normalize_one(smp_ring[slot], sum);
    o.last_of_pixel = lastf;
    return o;
  endfunction

  task automatic predict_word(input lrn_ccf_pkg::in_word_t w);
    int unsigned k;
    int unsigned pre;
    int unsigned post;
    int unsigned d;
    int signed sx;
    k = chan_idx;
    if (k == 0) win_len = (win_cfg == 0) ? 1 : win_cfg;
    pre = (win_len - 1) / 2;
    post = win_len - 1 - pre;
    sx = w.sample;
    smp_ring[ring_head] = w.sample;
    sq_ring[ring_head] = 32'(sx * sx);
    if (!w.last_channel) begin
      if (k >= post) expected_norm.push_back(lrn_of(k, post, pre, post, 1'b0));
      chan_idx = (k < 65535) ? k + 1 : k;
    end else begin
      d = (post < k) ? post : k;
      forever begin
        expected_norm.push_back(lrn_of(k, d, pre, post, d == 0));
        if (d == 0) break;
        d--;
      end
      chan_idx = 0;
    end
    ring_head = ring_head + 4'd1;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = in_valid_i && !in_stall_o;
      if (took) predict_word(in_word_i);
      if (!in_valid_i || took) begin
        if (gap_left == 0 && pending_words.size() > 0) begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          gap_left <= no_idle ? 0 : $urandom_range(0, 13);
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    int unsigned n;
    lrn_ccf_pkg::out_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_norm.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", out_word_o);
        end else begin
          exp_w = expected_norm.pop_front();
          if (out_word_o.normalized !== exp_w.normalized ||
              out_word_o.last_of_pixel !== exp_w.last_of_pixel) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected norm %h last %b, got norm %h last %b",
                       exp_w.normalized, exp_w.last_of_pixel,
                       out_word_o.normalized, out_word_o.last_of_pixel);
          end
        end
        n = no_idle ? 0 : $urandom_range(0, 13);
        stall_left <= n;
        out_stall_i <= (n != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= (stall_left > 1);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("lrn_cross_channel_forward_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [lrn_ccf_pkg::CfgIdxW-1:0] idx,
                           input logic [lrn_ccf_pkg::AlphaW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      lrn_ccf_pkg::RegAlpha: alpha_cfg = val;
      lrn_ccf_pkg::RegBeta: beta_cfg = val[7:0];
      lrn_ccf_pkg::RegWindow: win_cfg = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [23:0] a, input logic [7:0] b, input logic [3:0] w);
    write_reg(lrn_ccf_pkg::RegAlpha, a);
    write_reg(lrn_ccf_pkg::RegBeta, 24'(b));
    write_reg(lrn_ccf_pkg::RegWindow, 24'(w));
  endtask

  // checked between edges, once every edge update has landed
  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_norm.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_word(input logic [15:0] s, input bit lastf);
    lrn_ccf_pkg::in_word_t w;
    w.sample = s;
    w.last_channel = lastf;
    pending_words.push_back(w);
  endtask

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'($urandom_range(0, 2047) - 1024);
  endfunction

  task automatic add_pixel(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++) add_word(rand_sample(), close && i == len - 1);
  endtask

  initial begin
    int unsigned total;
    int unsigned len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults, extremes of the sample
    set_regs(lrn_ccf_pkg::AlphaReset, lrn_ccf_pkg::BetaReset, lrn_ccf_pkg::WindowReset);
    add_word(16'h7FFF, 0);
    add_word(16'h8000, 0);
    add_word(16'h0000, 0);
    add_word(16'hFFFF, 0);
    add_word(16'h0001, 0);
    add_word(16'h0100, 0);
    add_word(16'hFF00, 1);
    add_word(16'h7FFF, 1);
    add_word(16'h8000, 0);
    add_word(16'h1234, 1);
    drain();

    set_regs(24'hFFFFFF, 8'hFF, 4'd15);
    add_pixel(16, 1);
    add_pixel(3, 1);
    drain();

    set_regs(24'd0, 8'd0, 4'd0);
    add_word(16'h7FFF, 0);
    add_word(16'h8000, 0);
    add_word(16'h5555, 1);
    drain();

    // new settings in the middle of a pixel
    set_regs(24'd40000, 8'd128, 4'd7);
    add_pixel(3, 0);
    drain();
    set_regs(24'd5000, 8'd100, 4'd1);
    add_pixel(4, 1);
    drain();

    for (int p = 0; p < 7; p++) begin
      no_idle = (p % 3 == 0);
      set_regs(24'($urandom >> (8 + $urandom_range(0, 16))), 8'($urandom),
               4'($urandom_range(0, 15)));
      total = 0;
      while (total < 40) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
        add_pixel(len, !(total + len >= 40 && p % 2 == 1));
        total += len;
      end
      drain();
    end
    no_idle = 1'b0;

    if (mismatches == 0) begin
      $display("lrn_cross_channel_forward_core regression: pass");
    end else begin
      $display("lrn_cross_channel_forward_core regression: fail");
    end
    $finish;
  end

endmodule
